/* hdl/fmpd_pkg.sv */
// ============================================================================
// fmpd_pkg: FM phase discriminator shared definitions
// Widths, the CORDIC arctangent table and the controller state type.
// ============================================================================
package fmpd_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int PH_W             = 24;
    localparam int STEP_W           = 25;
    localparam int SUM_W            = 28;
    localparam int HIST_DEPTH       = 10;
    localparam int CNT_W            = 4;
    localparam int WINDOW_DEF       = 10;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_LEN        = 24;
    localparam int K_W              = 5;
    localparam int Z_W              = 27;
    localparam int XY_W             = 36;
    localparam int PROD_W           = 33;
    localparam int TURN_W           = Z_W - 8;
    localparam int DIV_W            = SUM_W + 1;
    localparam int DCNT_W           = 5;
    localparam int OUT_TDATA_W      = 80;

    localparam logic signed [STEP_W-1:0] PH_MAX = 25'sd8388607;
    localparam logic signed [STEP_W-1:0] PH_MIN = -25'sd8388608;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CSTART,
        ST_CORDIC,
        ST_UNWRAP,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } t_state;

    // atan(2^-k) in turns, 24 fractional bits
    function automatic logic signed [Z_W-1:0] angle(input logic [K_W-1:0] k);
        logic signed [Z_W-1:0] a;
        case (k)
            5'd0:    a = 27'sd2097152;
            5'd1:    a = 27'sd1238021;
            5'd2:    a = 27'sd654136;
            5'd3:    a = 27'sd332050;
            5'd4:    a = 27'sd166669;
            5'd5:    a = 27'sd83416;
            5'd6:    a = 27'sd41718;
            5'd7:    a = 27'sd20860;
            5'd8:    a = 27'sd10430;
            5'd9:    a = 27'sd5215;
            5'd10:   a = 27'sd2608;
            5'd11:   a = 27'sd1304;
            5'd12:   a = 27'sd652;
            5'd13:   a = 27'sd326;
            5'd14:   a = 27'sd163;
            5'd15:   a = 27'sd81;
            5'd16:   a = 27'sd41;
            5'd17:   a = 27'sd20;
            5'd18:   a = 27'sd10;
            5'd19:   a = 27'sd5;
            5'd20:   a = 27'sd3;
            5'd21:   a = 27'sd1;
            5'd22:   a = 27'sd1;
            default: a = 27'sd0;
        endcase
        return a;
    endfunction

endpackage

/* hdl/fmpd_cordic.sv */
// ============================================================================
// fmpd_cordic: iterative vectoring CORDIC
// Angle of (x, y) in turns, one micro-rotation per cycle, rounded to Q.16.
// ============================================================================
module fmpd_cordic #(
    parameter int CORDIC_STEPS = fmpd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [fmpd_pkg::PROD_W-1:0]     i_x,
    input  logic signed [fmpd_pkg::PROD_W-1:0]     i_y,
    output logic                                   o_done,
    output logic signed [fmpd_pkg::TURN_W-1:0]     o_turns
);
    localparam int NSTEPS = (CORDIC_STEPS < fmpd_pkg::ANGLE_LEN) ?
                            CORDIC_STEPS : fmpd_pkg::ANGLE_LEN;

    logic signed [fmpd_pkg::XY_W-1:0] r_x, r_y, x_ext, y_ext, dx, dy;
    logic signed [fmpd_pkg::Z_W-1:0]  r_z, z_rnd;
    logic [fmpd_pkg::K_W-1:0]         r_k;
    logic                             r_busy, r_done;

    assign x_ext = fmpd_pkg::XY_W'(i_x);
    assign y_ext = fmpd_pkg::XY_W'(i_y);
    assign dx    = r_y >>> r_k;
    assign dy    = r_x >>> r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_k <= '0;
                if (i_x == '0 && i_y == '0) begin
                    // zero vector: angle is zero, skip the rotations
                    r_z    <= '0;
                    r_done <= 1'b1;
                end else if (i_x < 0) begin
                    // left half plane: turn by half a turn first
                    r_x    <= -x_ext;
                    r_y    <= -y_ext;
                    r_z    <= (i_y >= 0) ? 27'sd8388608 : -27'sd8388608;
                    r_busy <= 1'b1;
                end else begin
                    r_x    <= x_ext;
                    r_y    <= y_ext;
                    r_z    <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_y > 0) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + fmpd_pkg::angle(r_k);
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - fmpd_pkg::angle(r_k);
                end
                r_k <= r_k + 1'b1;
                if (r_k == fmpd_pkg::K_W'(NSTEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign z_rnd   = r_z + 27'sd128;
    assign o_turns = z_rnd[fmpd_pkg::Z_W-1:8];
    assign o_done  = r_done;
endmodule

/* hdl/fm_phase_discriminator_unit.sv */
// ============================================================================
// fm_phase_discriminator_unit: FM quadrature discriminator, CORDIC atan2
// Phase step of consecutive IQ samples, unwrapped running phase, window
// mean and last step, all in turns with 16 fractional bits.
// ============================================================================
//
//  channel | dir | tdata (low bit up)                         | tuser
//  --------+-----+--------------------------------------------+--------------
//  s       | in  | sample_i[15:0], sample_q[31:16]            | block_start
//  m       | out | freq_turns[23:0], smoothed_phase[47:24],   | saturated
//          |     | phase_step[72:48], zero pad [79:73]        |
//
//  One sample at a time. A block start sample only seeds the previous
//  sample. Any other sample runs through the shared 16x16 multiplier, the
//  CORDIC start and loop (the loop is skipped for a zero product), the
//  unwrap, the window sum over eff ring entries (one ring entry a cycle),
//  the bit-serial divider and the output state, eff = min(history count, WINDOW, 10).
//  Reset clears the running phase, the history count and pointer and all
//  handshake state. A stalled result sits in the output register; the next
//  sample is accepted meanwhile and waits in the final state only if its
//  result is done before the earlier one has been taken.
//
module fm_phase_discriminator_unit #(
    parameter int WINDOW       = fmpd_pkg::WINDOW_DEF,
    parameter int CORDIC_STEPS = fmpd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [31:0]                         i_s_tdata,  // sample_i, sample_q
    input  logic [0:0]                          i_s_tuser,  // block_start
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [fmpd_pkg::OUT_TDATA_W-1:0]    o_m_tdata,  // freq, smoothed, step
    output logic [0:0]                          o_m_tuser   // saturated
);
    localparam int EFF_MAX = (WINDOW < fmpd_pkg::HIST_DEPTH) ? WINDOW : fmpd_pkg::HIST_DEPTH;

    fmpd_pkg::t_state r_state, n_state;

    // sample registers
    logic signed [fmpd_pkg::SAMPLE_W-1:0] r_ci, r_cq, r_pi, r_pq;
    logic signed [fmpd_pkg::SAMPLE_W-1:0] mul_a, mul_b;
    logic signed [31:0]                   prod;
    logic signed [fmpd_pkg::PROD_W-1:0]   r_re, r_im;
    logic [1:0]                           r_mcnt;

    // CORDIC
    logic                                 cordic_start, cordic_done;
    logic signed [fmpd_pkg::TURN_W-1:0]   cordic_turns;
    logic signed [fmpd_pkg::TURN_W-1:0]   r_d;

    // unwrap and history
    logic signed [fmpd_pkg::PH_W-1:0]     r_rp, r_last;
    logic signed [fmpd_pkg::PH_W-1:0]     r_hist [fmpd_pkg::HIST_DEPTH];
    logic [fmpd_pkg::CNT_W-1:0]           r_cnt, r_ptr, r_idx, r_k, r_eff;
    logic [fmpd_pkg::CNT_W-1:0]           n_cnt, n_eff;
    logic [15:0]                          diff16;
    logic signed [fmpd_pkg::STEP_W-1:0]   nv_raw;
    logic signed [fmpd_pkg::PH_W-1:0]     nv;
    logic                                 nv_sat, r_sat;
    logic signed [fmpd_pkg::STEP_W-1:0]   r_step;

    // window sum and divider
    logic signed [fmpd_pkg::SUM_W-1:0]    r_acc, acc_next, acc_mag;
    logic [fmpd_pkg::DIV_W-1:0]           r_div;
    logic [fmpd_pkg::CNT_W-1:0]           r_rem;
    logic [fmpd_pkg::CNT_W:0]             trial;
    logic                                 trial_ge;
    logic [fmpd_pkg::DCNT_W-1:0]          r_dcnt;
    logic                                 r_neg;
    logic [fmpd_pkg::PH_W-1:0]            mean;

    // output register
    logic                                 r_ovalid;
    logic [fmpd_pkg::OUT_TDATA_W-1:0]     r_odata;
    logic                                 r_osat;
    logic                                 out_load;

    fmpd_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_x     (r_re),
        .i_y     (r_im),
        .o_done  (cordic_done),
        .o_turns (cordic_turns)
    );

    // shared multiplier: ci*pi, cq*pq, cq*pi, ci*pq
    always_comb begin
        case (r_mcnt)
            2'd0:    begin mul_a = r_ci; mul_b = r_pi; end
            2'd1:    begin mul_a = r_cq; mul_b = r_pq; end
            2'd2:    begin mul_a = r_cq; mul_b = r_pi; end
            default: begin mul_a = r_ci; mul_b = r_pq; end
        endcase
    end
    assign prod = mul_a * mul_b;

    // unwrap: move the step by whole turns to within half a turn, then clamp
    assign diff16 = r_d[15:0] - r_rp[15:0];
    assign nv_raw = fmpd_pkg::STEP_W'(r_rp) + fmpd_pkg::STEP_W'($signed(diff16));
    always_comb begin
        nv_sat = 1'b0;
        nv     = nv_raw[fmpd_pkg::PH_W-1:0];
        if (nv_raw > fmpd_pkg::PH_MAX) begin
            nv     = fmpd_pkg::PH_MAX[fmpd_pkg::PH_W-1:0];
            nv_sat = 1'b1;
        end else if (nv_raw < fmpd_pkg::PH_MIN) begin
            nv     = fmpd_pkg::PH_MIN[fmpd_pkg::PH_W-1:0];
            nv_sat = 1'b1;
        end
    end

    assign n_cnt = (r_cnt < fmpd_pkg::CNT_W'(fmpd_pkg::HIST_DEPTH)) ? r_cnt + 1'b1 : r_cnt;
    assign n_eff = (n_cnt < fmpd_pkg::CNT_W'(EFF_MAX)) ? n_cnt : fmpd_pkg::CNT_W'(EFF_MAX);

    assign acc_next = r_acc + fmpd_pkg::SUM_W'(r_hist[r_idx]);
    assign acc_mag  = (acc_next < 0) ? -acc_next : acc_next;

    // one restoring division step per cycle
    assign trial    = {r_rem, r_div[fmpd_pkg::DIV_W-1]};
    assign trial_ge = (trial >= {1'b0, r_eff});
    assign mean     = r_neg ? -r_div[fmpd_pkg::PH_W-1:0] : r_div[fmpd_pkg::PH_W-1:0];

    assign out_load = (r_state == fmpd_pkg::ST_OUT) && (!r_ovalid || i_m_tready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fmpd_pkg::ST_IDLE:   if (i_s_tvalid && !i_s_tuser[0]) n_state = fmpd_pkg::ST_MUL;
            fmpd_pkg::ST_MUL:    if (r_mcnt == 2'd3) n_state = fmpd_pkg::ST_CSTART;
            fmpd_pkg::ST_CSTART: n_state = fmpd_pkg::ST_CORDIC;
            fmpd_pkg::ST_CORDIC: if (cordic_done) n_state = fmpd_pkg::ST_UNWRAP;
            fmpd_pkg::ST_UNWRAP: n_state = fmpd_pkg::ST_SUM;
            fmpd_pkg::ST_SUM:    if (r_k == r_eff - 1'b1) n_state = fmpd_pkg::ST_DIV;
            fmpd_pkg::ST_DIV:
                if (r_dcnt == fmpd_pkg::DCNT_W'(fmpd_pkg::DIV_W - 1)) n_state = fmpd_pkg::ST_OUT;
            fmpd_pkg::ST_OUT:    if (out_load) n_state = fmpd_pkg::ST_IDLE;
            default:             n_state = fmpd_pkg::ST_IDLE;
        endcase
    end

    // outputs of the controller
    always_comb begin
        o_s_tready   = (r_state == fmpd_pkg::ST_IDLE);
        cordic_start = (r_state == fmpd_pkg::ST_CSTART);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fmpd_pkg::ST_IDLE;
            r_rp     <= '0;
            r_cnt    <= '0;
            r_ptr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            // load a new result, or drop the one just taken
            if (out_load) r_ovalid <= 1'b1;
            else if (i_m_tready) r_ovalid <= 1'b0;

            case (r_state)
                fmpd_pkg::ST_IDLE: begin
                    // capture the request; a block start only seeds prev
                    r_mcnt <= '0;
                    r_re   <= '0;
                    r_im   <= '0;
                    if (i_s_tvalid) begin
                        r_ci <= i_s_tdata[15:0];
                        r_cq <= i_s_tdata[31:16];
                        if (i_s_tuser[0]) begin
                            r_pi <= i_s_tdata[15:0];
                            r_pq <= i_s_tdata[31:16];
                        end
                    end
                end
                fmpd_pkg::ST_MUL: begin
                    r_mcnt <= r_mcnt + 1'b1;
                    if (r_mcnt == 2'd3) begin
                        r_im <= r_im - fmpd_pkg::PROD_W'(prod);
                        // current sample becomes prev
                        r_pi <= r_ci;
                        r_pq <= r_cq;
                    end else if (r_mcnt == 2'd2) begin
                        r_im <= r_im + fmpd_pkg::PROD_W'(prod);
                    end else begin
                        r_re <= r_re + fmpd_pkg::PROD_W'(prod);
                    end
                end
                fmpd_pkg::ST_CORDIC: begin
                    if (cordic_done) r_d <= cordic_turns;
                end
                fmpd_pkg::ST_UNWRAP: begin
                    r_rp         <= nv;
                    r_sat        <= nv_sat;
                    r_hist[r_ptr] <= nv;
                    r_ptr        <= (r_ptr == fmpd_pkg::CNT_W'(fmpd_pkg::HIST_DEPTH - 1)) ?
                                    '0 : r_ptr + 1'b1;
                    r_cnt        <= n_cnt;
                    r_eff        <= n_eff;
                    r_step       <= (r_cnt != '0) ?
                                    fmpd_pkg::STEP_W'(nv) - fmpd_pkg::STEP_W'(r_last) : '0;
                    r_last       <= nv;
                    r_idx        <= r_ptr;
                    r_k          <= '0;
                    r_acc        <= '0;
                end
                fmpd_pkg::ST_SUM: begin
                    // walk back through the ring, newest first
                    r_acc <= acc_next;
                    r_k   <= r_k + 1'b1;
                    r_idx <= (r_idx == '0) ? fmpd_pkg::CNT_W'(fmpd_pkg::HIST_DEPTH - 1) :
                             r_idx - 1'b1;
                    r_neg <= (acc_next < 0);
                    r_div <= fmpd_pkg::DIV_W'(acc_mag) + fmpd_pkg::DIV_W'(r_eff >> 1);
                    r_rem <= '0;
                    r_dcnt <= '0;
                end
                fmpd_pkg::ST_DIV: begin
                    r_rem  <= trial_ge ? fmpd_pkg::CNT_W'(trial - {1'b0, r_eff}) :
                              trial[fmpd_pkg::CNT_W-1:0];
                    r_div  <= {r_div[fmpd_pkg::DIV_W-2:0], trial_ge};
                    r_dcnt <= r_dcnt + 1'b1;
                end
                fmpd_pkg::ST_OUT: begin
                    if (out_load) begin
                        r_odata  <= {7'd0, r_step, mean, r_rp};
                        r_osat   <= r_sat;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_osat;

    // history bookkeeping stays in range
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= fmpd_pkg::CNT_W'(fmpd_pkg::HIST_DEPTH))
        else $error("history count out of range");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr < fmpd_pkg::CNT_W'(fmpd_pkg::HIST_DEPTH))
        else $error("history pointer out of range");

    // a phase sample blocks further requests while it is at work
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && !i_s_tuser[0]) |=> !o_s_tready)
        else $error("request accepted while busy");

    // the CORDIC finishes only while the controller waits on it
    a_cordic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cordic_done |-> (r_state == fmpd_pkg::ST_CORDIC))
        else $error("unexpected CORDIC completion");

    // the window never exceeds what the history holds
    a_eff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fmpd_pkg::ST_SUM) |-> (r_eff != '0 && r_eff <= r_cnt))
        else $error("window size inconsistent with history");
endmodule
